/* hdl/blcp_pkg.sv */
// ----------------------------------------------------------------------------
// blcp_pkg
// Shared types and operation codes of the level bucket capacity pruner.
// ----------------------------------------------------------------------------
`default_nettype none

package blcp_pkg;

  localparam int OP_W        = 2;
  localparam int LEVEL_W     = 6;
  localparam int HANDLE_W    = 32;
  localparam int SIZE_OUT_W  = 11;
  localparam int TOTAL_OUT_W = 17;

  localparam logic [OP_W-1:0] OP_PUT  = 2'd0;
  localparam logic [OP_W-1:0] OP_PRUNE = 2'd1;
  localparam logic [OP_W-1:0] OP_SIZE = 2'd2;
  localparam logic [OP_W-1:0] OP_PEEK = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [LEVEL_W-1:0]  level;
    logic [HANDLE_W-1:0] entry_handle;
  } in_item_t;

  typedef struct packed {
    logic [SIZE_OUT_W-1:0]  level_size;
    logic [TOTAL_OUT_W-1:0] total_entries;
    logic [HANDLE_W-1:0]    first_handle;
    logic                   first_valid;
    logic                   put_dropped;
  } out_item_t;

endpackage

`default_nettype wire

/* hdl/blcp_ram.sv */
// ----------------------------------------------------------------------------
// blcp_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module blcp_ram #(
  parameter int DW    = 11,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [DW-1:0]            wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [DW-1:0]            rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* hdl/blcp_ctrl.sv */
// ----------------------------------------------------------------------------
// blcp_ctrl
// Sequencer of the pruner: read-modify-write of the count memories for puts,
// reads of them for queries, the level walk for the end-of-cycle prune, and
// the clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module blcp_ctrl #(
  parameter int LEVELS   = 64,
  parameter int CAPACITY = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire blcp_pkg::in_item_t            in_data,
  output logic                               out_valid,
  output blcp_pkg::out_item_t                out_data,
  output logic                               live_we,
  output logic                               vis_we,
  output logic [$clog2(LEVELS)-1:0]          wr_addr,
  output logic [$clog2(CAPACITY+1)-1:0]      live_wdata,
  output logic [$clog2(CAPACITY+1)-1:0]      vis_wdata,
  output logic [$clog2(LEVELS)-1:0]          rd_addr,
  input  wire logic [$clog2(CAPACITY+1)-1:0] live_rdata,
  input  wire logic [$clog2(CAPACITY+1)-1:0] vis_rdata
);

  import blcp_pkg::*;

  localparam int AW = $clog2(LEVELS);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int TW = $clog2(LEVELS * CAPACITY + 1);

  localparam logic [AW-1:0] LAST_IDX = AW'(LEVELS - 1);
  localparam logic [CW-1:0] CAP_C    = CW'(CAPACITY);
  localparam logic [TW-1:0] CAP_T    = TW'(CAPACITY);

  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;
  localparam logic [1:0] ST_WALK = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [AW-1:0]       idx_r, idx_nxt;
  logic [TW-1:0]       sum_r, sum_nxt;
  logic [TW-1:0]       total_r, total_nxt;
  logic [HANDLE_W-1:0] first_r, first_nxt;
  logic                prune_en_r, prune_en_nxt;
  logic                cut_r, cut_nxt;
  logic [OP_W-1:0]     op_r, op_nxt;
  logic [AW-1:0]       addr_r, addr_nxt;
  logic                lvl_ok_r, lvl_ok_nxt;
  logic                lvl0_r, lvl0_nxt;
  logic [HANDLE_W-1:0] handle_r, handle_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_r, out_nxt;

  logic          is_last;
  logic [TW-1:0] sum_plus;
  logic          over;
  logic [CW-1:0] cut_cnt;

  assign is_last  = (idx_r == LAST_IDX);
  assign sum_plus = sum_r + TW'(live_rdata);
  assign over     = prune_en_r && (sum_plus > CAP_T);
  assign cut_cnt  = CW'(CAP_T - sum_r);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    sum_nxt       = sum_r;
    total_nxt     = total_r;
    first_nxt     = first_r;
    prune_en_nxt  = prune_en_r;
    cut_nxt       = cut_r;
    op_nxt        = op_r;
    addr_nxt      = addr_r;
    lvl_ok_nxt    = lvl_ok_r;
    lvl0_nxt      = lvl0_r;
    handle_nxt    = handle_r;
    out_valid_nxt = 1'b0;
    out_nxt       = '0;
    live_we       = 1'b0;
    vis_we        = 1'b0;
    wr_addr       = idx_r;
    live_wdata    = '0;
    vis_wdata     = '0;
    rd_addr       = idx_r;

    unique case (state_r)
      ST_CLR: begin
        live_we = 1'b1;
        vis_we  = 1'b1;
        if (is_last) begin
          idx_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end

      ST_IDLE: begin
        // Peek needs the live count of level 0; a prune starts its walk there.
        if (in_data.op == OP_PUT || in_data.op == OP_SIZE) begin
          rd_addr = AW'(in_data.level);
        end else begin
          rd_addr = '0;
        end
        if (start) begin
          op_nxt     = in_data.op;
          addr_nxt   = AW'(in_data.level);
          lvl_ok_nxt = (32'(in_data.level) < LEVELS);
          lvl0_nxt   = (in_data.level == '0);
          handle_nxt = in_data.entry_handle;
          if (in_data.op == OP_PRUNE) begin
            idx_nxt      = '0;
            sum_nxt      = '0;
            cut_nxt      = 1'b0;
            prune_en_nxt = (total_r >= CAP_T);
            state_nxt    = ST_WALK;
          end else begin
            state_nxt = ST_EXEC;
          end
        end
      end

      ST_EXEC: begin
        wr_addr       = addr_r;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
        case (op_r)
          OP_PUT: begin
            if (!lvl_ok_r || live_rdata >= CAP_C) begin
              out_nxt.put_dropped = 1'b1;
            end else begin
              live_we    = 1'b1;
              live_wdata = live_rdata + CW'(1);
              total_nxt  = total_r + TW'(1);
              if (lvl0_r && live_rdata == '0) begin
                first_nxt = handle_r;
              end
            end
          end
          OP_SIZE: begin
            if (lvl_ok_r) begin
              out_nxt.level_size = SIZE_OUT_W'(vis_rdata);
            end
          end
          default: begin
            if (live_rdata != '0) begin
              out_nxt.first_valid  = 1'b1;
              out_nxt.first_handle = first_r;
            end
          end
        endcase
      end

      default: begin
        // One level per cycle; the next level is read ahead while this one
        // is written back, and the read is dropped when the walk stops.
        rd_addr = idx_r + AW'(1);
        if (live_rdata == '0) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          if (cut_r) begin
            live_we   = 1'b1;
            vis_we    = 1'b1;
            total_nxt = total_r - TW'(live_rdata);
          end else if (over) begin
            // Cut this level back to what is left of the capacity. A level
            // cut to nothing keeps its old snapshot.
            live_we    = 1'b1;
            live_wdata = cut_cnt;
            vis_we     = (cut_cnt != '0);
            vis_wdata  = cut_cnt;
            total_nxt  = total_r - TW'(live_rdata - cut_cnt);
            cut_nxt    = 1'b1;
          end else begin
            vis_we    = 1'b1;
            vis_wdata = live_rdata;
            sum_nxt   = sum_plus;
          end
          if (is_last) begin
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            idx_nxt = idx_r + AW'(1);
          end
        end
      end
    endcase

    if (out_valid_nxt) begin
      out_nxt.total_entries = TOTAL_OUT_W'(total_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      idx_r       <= '0;
      total_r     <= '0;
      first_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      total_r     <= total_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r      <= sum_nxt;
    prune_en_r <= prune_en_nxt;
    cut_r      <= cut_nxt;
    op_r       <= op_nxt;
    addr_r     <= addr_nxt;
    lvl_ok_r   <= lvl_ok_nxt;
    lvl0_r     <= lvl0_nxt;
    handle_r   <= handle_nxt;
    if (out_valid_nxt) begin
      out_r <= out_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_result_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == ST_IDLE)
    else $error("result strobe outside idle state");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy && !out_valid_r)
    else $error("accepted transaction did not make the block busy");

  a_drop_keeps_total: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.put_dropped) |-> $stable(total_r))
    else $error("dropped put changed the total");

  a_total_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.total_entries == TOTAL_OUT_W'(total_r))
    else $error("reported total differs from the running total");

endmodule

`default_nettype wire

/* hdl/level_bucket_capacity_pruner_core.sv */
// ----------------------------------------------------------------------------
// level_bucket_capacity_pruner_core
// Per-level entry counts with a capacity prune and a visible snapshot.
//
//   channel   ports                       handshake
//   input     start, busy, in_data        taken when start is high, busy low
//   result    out_valid, out_data         one-cycle strobe, cannot stall
//
// Put, size and peek read the count memories in the idle state, then write
// back and register the result in the execute state before the next
// transaction is taken. A prune walks the levels from level 0 and reads 1 to
// LEVELS of them; the walk handles one level per cycle on the single read
// and write port of each count memory. After reset a clearing pass zeroes
// both memories with busy high. The result strobe rises in the cycle after
// the last working cycle, while busy is low.
// ----------------------------------------------------------------------------
`default_nettype none

module level_bucket_capacity_pruner_core #(
  parameter int LEVELS   = 64,
  parameter int CAPACITY = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire blcp_pkg::in_item_t in_data,
  output logic                    out_valid,
  output blcp_pkg::out_item_t     out_data
);

  import blcp_pkg::*;

  localparam int AW = $clog2(LEVELS);
  localparam int CW = $clog2(CAPACITY + 1);

  logic          live_we;
  logic          vis_we;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] live_wdata;
  logic [CW-1:0] vis_wdata;
  logic [CW-1:0] live_rdata;
  logic [CW-1:0] vis_rdata;

  blcp_ram #(
    .DW    (CW),
    .DEPTH (LEVELS)
  ) u_live_ram (
    .clk     (clk),
    .wr_en   (live_we),
    .wr_addr (wr_addr),
    .wr_data (live_wdata),
    .rd_addr (rd_addr),
    .rd_data (live_rdata)
  );

  blcp_ram #(
    .DW    (CW),
    .DEPTH (LEVELS)
  ) u_vis_ram (
    .clk     (clk),
    .wr_en   (vis_we),
    .wr_addr (wr_addr),
    .wr_data (vis_wdata),
    .rd_addr (rd_addr),
    .rd_data (vis_rdata)
  );

  blcp_ctrl #(
    .LEVELS   (LEVELS),
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .live_we    (live_we),
    .vis_we     (vis_we),
    .wr_addr    (wr_addr),
    .live_wdata (live_wdata),
    .vis_wdata  (vis_wdata),
    .rd_addr    (rd_addr),
    .live_rdata (live_rdata),
    .vis_rdata  (vis_rdata)
  );

endmodule

`default_nettype wire
